// ===== hw/rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the segment point constraint unit.
// ----------------------------------------------------------------------------
package spc_pkg;

  // coordinate and fraction widths
  localparam int CW   = 24;        // coordinate width
  localparam int TF   = 24;        // projection fraction bits
  localparam int DW   = CW + 1;    // coordinate difference width
  localparam int PW   = 2 * DW;    // product width
  localparam int L2W  = PW;        // squared length width (sum of three squares)
  localparam int DOTW = PW + 2;    // signed dot product width
  localparam int THRW = 52;        // threshold register width
  localparam int OPW  = 2;

  // opcodes
  localparam logic [OPW-1:0] OP_MOVE1 = 2'd0;
  localparam logic [OPW-1:0] OP_MOVE2 = 2'd1;
  localparam logic [OPW-1:0] OP_PROJ  = 2'd2;
  localparam logic [OPW-1:0] OP_BAD   = 2'd3;

  // changed point codes
  localparam logic [1:0] CP_END1 = 2'd0;
  localparam logic [1:0] CP_END2 = 2'd1;
  localparam logic [1:0] CP_PT   = 2'd2;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef diff_t [2:0] dvec_t;

  // item state through the divider and the final scale
  typedef struct packed {
    logic             ok;
    logic [1:0]       which;
    logic             is_div;
    vec_t             res;
    dvec_t            d;
    logic [L2W-1:0]   rem;
    logic [L2W-1:0]   len2;
    logic [TF-1:0]    f;
  } div_t;

endpackage

// ===== hw/rtl/segment_point_constraint_unit.sv =====
// ----------------------------------------------------------------------------
// segment_point_constraint_unit
// Moves a segment end onto a point or clamps a point onto a segment.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | opcode, end1, end2, pt
//  out_    | output    | out_valid/out_stall| ok, changed_point, new x/y/z
//  cfg_    | input     | cfg_we             | degenerate threshold
//
// One item per cycle unless the output stalls: three stages of differences,
// products and sums, one decision stage, one restoring divider stage per
// fraction bit, one scale multiply stage and the output register.
// Reset (synchronous) clears all valid bits and sets the threshold to 1.
// A stall on the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module segment_point_constraint_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [spc_pkg::THRW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spc_pkg::OPW-1:0]     in_opcode,
  input  logic signed [spc_pkg::CW-1:0] in_end1_x,
  input  logic signed [spc_pkg::CW-1:0] in_end1_y,
  input  logic signed [spc_pkg::CW-1:0] in_end1_z,
  input  logic signed [spc_pkg::CW-1:0] in_end2_x,
  input  logic signed [spc_pkg::CW-1:0] in_end2_y,
  input  logic signed [spc_pkg::CW-1:0] in_end2_z,
  input  logic signed [spc_pkg::CW-1:0] in_pt_x,
  input  logic signed [spc_pkg::CW-1:0] in_pt_y,
  input  logic signed [spc_pkg::CW-1:0] in_pt_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [1:0]                  out_changed_point,
  output logic signed [spc_pkg::CW-1:0] out_new_x,
  output logic signed [spc_pkg::CW-1:0] out_new_y,
  output logic signed [spc_pkg::CW-1:0] out_new_z
);

  localparam int CW   = spc_pkg::CW;
  localparam int TF   = spc_pkg::TF;
  localparam int PW   = spc_pkg::PW;
  localparam int L2W  = spc_pkg::L2W;
  localparam int DOTW = spc_pkg::DOTW;
  localparam int THRW = spc_pkg::THRW;

  logic en;
  logic [THRW-1:0] thr_r;

  // stage 1: differences
  logic v1_r;
  logic [spc_pkg::OPW-1:0] op1_r;
  spc_pkg::vec_t e1_1_r, e2_1_r, p1_r;
  spc_pkg::dvec_t d1_r, b1_r, pa1_r;

  // stage 2: products
  logic v2_r;
  logic [spc_pkg::OPW-1:0] op2_r;
  spc_pkg::vec_t e1_2_r, e2_2_r, p2_r;
  spc_pkg::dvec_t d2_r;
  logic signed [PW-1:0] dd2_r [3];
  logic signed [PW-1:0] bb2_r [3];
  logic signed [PW-1:0] dp2_r [3];

  // stage 3: sums
  logic v3_r;
  logic [spc_pkg::OPW-1:0] op3_r;
  spc_pkg::vec_t e1_3_r, e2_3_r, p3_r;
  spc_pkg::dvec_t d3_r;
  logic [L2W-1:0] len2_3_r, bsq_3_r;
  logic signed [DOTW-1:0] dot3_r;

  // divider chain, entry 0 is the decision stage
  logic dv_v_r [TF+1];
  spc_pkg::div_t dv_r [TF+1];
  spc_pkg::div_t dv_nxt [TF+1];

  // scale stage
  logic vm_r;
  logic mok_r;
  logic [1:0] mwhich_r;
  logic mdiv_r;
  spc_pkg::vec_t mres_r;
  logic signed [PW-1:0] mprod_r [3];

  // output register
  logic out_valid_r, ok_r;
  logic [1:0] which_r;
  spc_pkg::vec_t new_r;

  // pipeline advances unless a finished result is held back
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRW'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k <= TF; k++) dv_v_r[k] <= 1'b0;
      vm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      dv_v_r[0] <= v3_r;
      for (int k = 0; k < TF; k++) dv_v_r[k+1] <= dv_v_r[k];
      vm_r        <= dv_v_r[TF];
      out_valid_r <= vm_r;
    end
  end

  // stage 1: edge and point differences
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_opcode;
      e1_1_r <= {in_end1_z, in_end1_y, in_end1_x};
      e2_1_r <= {in_end2_z, in_end2_y, in_end2_x};
      p1_r   <= {in_pt_z, in_pt_y, in_pt_x};
      d1_r[0]  <= 25'(in_end2_x) - 25'(in_end1_x);
      d1_r[1]  <= 25'(in_end2_y) - 25'(in_end1_y);
      d1_r[2]  <= 25'(in_end2_z) - 25'(in_end1_z);
      pa1_r[0] <= 25'(in_pt_x) - 25'(in_end1_x);
      pa1_r[1] <= 25'(in_pt_y) - 25'(in_end1_y);
      pa1_r[2] <= 25'(in_pt_z) - 25'(in_end1_z);
      if (in_opcode == spc_pkg::OP_MOVE2) begin
        b1_r[0] <= 25'(in_pt_x) - 25'(in_end2_x);
        b1_r[1] <= 25'(in_pt_y) - 25'(in_end2_y);
        b1_r[2] <= 25'(in_pt_z) - 25'(in_end2_z);
      end else begin
        b1_r[0] <= 25'(in_pt_x) - 25'(in_end1_x);
        b1_r[1] <= 25'(in_pt_y) - 25'(in_end1_y);
        b1_r[2] <= 25'(in_pt_z) - 25'(in_end1_z);
      end
    end
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      e1_2_r <= e1_1_r;
      e2_2_r <= e2_1_r;
      p2_r   <= p1_r;
      d2_r   <= d1_r;
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= $signed(d1_r[i]) * $signed(d1_r[i]);
        bb2_r[i] <= $signed(b1_r[i]) * $signed(b1_r[i]);
        dp2_r[i] <= $signed(d1_r[i]) * $signed(pa1_r[i]);
      end
    end
  end

  // stage 3: squared lengths and dot product
  always_ff @(posedge clk) begin
    if (en) begin
      op3_r    <= op2_r;
      e1_3_r   <= e1_2_r;
      e2_3_r   <= e2_2_r;
      p3_r     <= p2_r;
      d3_r     <= d2_r;
      len2_3_r <= L2W'(dd2_r[0]) + L2W'(dd2_r[1]) + L2W'(dd2_r[2]);
      bsq_3_r  <= L2W'(bb2_r[0]) + L2W'(bb2_r[1]) + L2W'(bb2_r[2]);
      dot3_r   <= DOTW'(dp2_r[0]) + DOTW'(dp2_r[1]) + DOTW'(dp2_r[2]);
    end
  end

  // decision: pick the outcome, start the division when needed
  always_comb begin
    logic move_ok, degen, dot_le0, dot_ge;
    move_ok = len2_3_r < bsq_3_r;
    degen   = {{(THRW-L2W){1'b0}}, len2_3_r} < thr_r;
    dot_le0 = dot3_r[DOTW-1] || (dot3_r == '0);
    dot_ge  = $unsigned(dot3_r) >= {{(DOTW-L2W){1'b0}}, len2_3_r};
    dv_nxt[0]        = '0;
    dv_nxt[0].d      = d3_r;
    dv_nxt[0].rem    = dot3_r[L2W-1:0];
    dv_nxt[0].len2   = len2_3_r;
    case (op3_r)
      spc_pkg::OP_MOVE1, spc_pkg::OP_MOVE2: begin
        if (move_ok) begin
          dv_nxt[0].ok    = 1'b1;
          dv_nxt[0].which = op3_r;
          dv_nxt[0].res   = p3_r;
        end
      end
      spc_pkg::OP_PROJ: begin
        dv_nxt[0].ok    = 1'b1;
        dv_nxt[0].which = spc_pkg::CP_PT;
        if (degen) begin
          dv_nxt[0].res = e2_3_r;
        end else if (dot_le0) begin
          dv_nxt[0].res = e1_3_r;
        end else if (dot_ge) begin
          dv_nxt[0].res = e2_3_r;
        end else begin
          dv_nxt[0].res    = e1_3_r;
          dv_nxt[0].is_div = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // restoring divider, one fraction bit per stage
    for (int k = 0; k < TF; k++) begin
      logic [L2W:0] sh;
      sh = {dv_r[k].rem, 1'b0};
      dv_nxt[k+1] = dv_r[k];
      if (sh >= {1'b0, dv_r[k].len2}) begin
        dv_nxt[k+1].rem = L2W'(sh - {1'b0, dv_r[k].len2});
        dv_nxt[k+1].f   = {dv_r[k].f[TF-2:0], 1'b1};
      end else begin
        dv_nxt[k+1].rem = sh[L2W-1:0];
        dv_nxt[k+1].f   = {dv_r[k].f[TF-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= TF; k++) dv_r[k] <= dv_nxt[k];
    end
  end

  // scale the edge vector by the fraction
  always_ff @(posedge clk) begin
    if (en) begin
      mok_r    <= dv_r[TF].ok;
      mwhich_r <= dv_r[TF].which;
      mdiv_r   <= dv_r[TF].is_div;
      mres_r   <= dv_r[TF].res;
      for (int i = 0; i < 3; i++) begin
        mprod_r[i] <= PW'($signed(dv_r[TF].d[i]) * $signed({1'b0, dv_r[TF].f}));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r    <= mok_r;
      which_r <= mwhich_r;
      for (int i = 0; i < 3; i++) begin
        if (mdiv_r) begin
          new_r[i] <= mres_r[i] + mprod_r[i][TF+CW-1:TF];
        end else begin
          new_r[i] <= mres_r[i];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_changed_point = which_r;
  assign out_new_x         = new_r[0];
  assign out_new_y         = new_r[1];
  assign out_new_z         = new_r[2];

endmodule

// ===== hw/rtl/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks of the segment point constraint unit.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ok,
  input logic [1:0]                    out_changed_point,
  input logic signed [spc_pkg::CW-1:0] out_new_x,
  input logic signed [spc_pkg::CW-1:0] out_new_y,
  input logic signed [spc_pkg::CW-1:0] out_new_z
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a failed transfer carries a zero position and code
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      out_changed_point == spc_pkg::CP_END1 && out_new_x == '0 &&
      out_new_y == '0 && out_new_z == '0)
    else $error("failed result not zero");

  // a projection is always reported as ok
  a_proj_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed_point == spc_pkg::CP_PT |-> out_ok)
    else $error("projection without ok");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_x) && $stable(out_ok))
    else $error("stalled result changed");

endmodule

bind segment_point_constraint_unit spc_checker u_spc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ok            (out_ok),
  .out_changed_point (out_changed_point),
  .out_new_x         (out_new_x),
  .out_new_y         (out_new_y),
  .out_new_z         (out_new_z)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the segment point constraint unit: moves, projections and failing
// opcodes go in with random gaps and output stalls, and each result is
// compared with an exact fixed-point computation done on the bench side.
// ----------------------------------------------------------------------------
module tb;
  import spc_pkg::*;

  typedef struct {
    logic [1:0] op;
    coord_t     e1 [3];
    coord_t     e2 [3];
    coord_t     p  [3];
  } query_t;

  typedef struct {
    logic       ok;
    logic [1:0] which;
    coord_t     pos [3];
  } answer_t;

  // golden answers and their order of arrival
  class answer_board;
    answer_t     pending [$];
    logic [THRW-1:0] thr = 1;
    int          errors = 0;

    // exact geometry with wide signed math
    function answer_t predict(query_t q);
      answer_t r;
      logic signed [127:0] a [3];
      logic signed [127:0] b [3];
      logic signed [127:0] la, lb, dt, fr, pr;
      r.ok = 0; r.which = CP_END1;
      for (int i = 0; i < 3; i++) r.pos[i] = '0;
      if (q.op == OP_MOVE1 || q.op == OP_MOVE2) begin
        la = 0; lb = 0;
        for (int i = 0; i < 3; i++) begin
          if (q.op == OP_MOVE1) begin
            a[i] = q.e2[i] - q.e1[i]; b[i] = q.p[i] - q.e1[i];
          end else begin
            a[i] = q.e1[i] - q.e2[i]; b[i] = q.p[i] - q.e2[i];
          end
          la += a[i] * a[i]; lb += b[i] * b[i];
        end
        if (la < lb) begin
          r.ok = 1;
          r.which = (q.op == OP_MOVE1) ? CP_END1 : CP_END2;
          r.pos = q.p;
        end
      end else if (q.op == OP_PROJ) begin
        r.ok = 1; r.which = CP_PT;
        la = 0; dt = 0;
        for (int i = 0; i < 3; i++) begin
          a[i] = q.e2[i] - q.e1[i]; b[i] = q.p[i] - q.e1[i];
          la += a[i] * a[i]; dt += a[i] * b[i];
        end
        if (la < $signed({76'd0, thr})) r.pos = q.e2;
        else if (dt <= 0) r.pos = q.e1;
        else if (dt >= la) r.pos = q.e2;
        else begin
          fr = (dt <<< TF) / la;
          for (int i = 0; i < 3; i++) begin
            pr = a[i] * fr;
            r.pos[i] = q.e1[i] + coord_t'(pr >>> TF);
          end
        end
      end
      return r;
    endfunction

    function void note_query(query_t q);
      pending.push_back(predict(q));
    endfunction

    function void check_answer(answer_t got);
      answer_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.ok !== w.ok) begin
        $error("ok: expected %0d actual %0d", w.ok, got.ok); errors++;
      end
      if (got.which !== w.which) begin
        $error("changed_point: expected %0d actual %0d", w.which, got.which); errors++;
      end
      if (got.pos[0] !== w.pos[0]) begin
        $error("new_x: expected %0d actual %0d", w.pos[0], got.pos[0]); errors++;
      end
      if (got.pos[1] !== w.pos[1]) begin
        $error("new_y: expected %0d actual %0d", w.pos[1], got.pos[1]); errors++;
      end
      if (got.pos[2] !== w.pos[2]) begin
        $error("new_z: expected %0d actual %0d", w.pos[2], got.pos[2]); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 30;
  localparam int IDLE_LIMIT = 2000;

  logic clk, rst_n, cfg_we;
  logic [THRW-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall, out_ok;
  logic [OPW-1:0] in_opcode;
  logic [1:0] out_changed_point;
  coord_t in_end1_x, in_end1_y, in_end1_z, in_end2_x, in_end2_y, in_end2_z;
  coord_t in_pt_x, in_pt_y, in_pt_z, out_new_x, out_new_y, out_new_z;

  answer_board board;
  bit          stim_done;
  int          idle_cycles;

  segment_point_constraint_unit DUT (.*);

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // coordinate helpers
  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
      default: return ($urandom_range(0, 1)) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 5) ? 1 : (mode < 9) ? 0 : 2;
    q.op = $urandom_range(0, 9) < 4 ? OP_PROJ : OPW'($urandom_range(0, 3));
    for (int i = 0; i < 3; i++) begin
      q.e1[i] = rnd_coord(mode);
      q.e2[i] = rnd_coord(mode);
      q.p[i]  = rnd_coord(mode);
    end
    // occasional short or zero-length segments
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++) q.e2[i] = q.e1[i] + coord_t'($urandom_range(0, 2));
    return q;
  endfunction

  // valid stays high into a zero gap, so back-to-back items flow
  task automatic send_query(query_t q);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= q.op;
    {in_end1_x, in_end1_y, in_end1_z} <= {q.e1[0], q.e1[1], q.e1[2]};
    {in_end2_x, in_end2_y, in_end2_z} <= {q.e2[0], q.e2[1], q.e2[2]};
    {in_pt_x, in_pt_y, in_pt_z} <= {q.p[0], q.p[1], q.p[2]};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_query(q);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THRW-1:0] v);
    drain();
    cfg_we <= 1; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.thr = v;
  endtask

  // result side: random wait before each transfer, sampling at the rising edge
  initial begin
    int w;
    out_stall = 1;
    forever begin
      w = $urandom_range(0, 6);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.ok = out_ok; got.which = out_changed_point;
      got.pos[0] = out_new_x; got.pos[1] = out_new_y; got.pos[2] = out_new_z;
      board.check_answer(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    query_t q;
    logic [THRW-1:0] thr_set [4];
    board = new();
    stim_done = 0; idle_cycles = 0;
    rst_n = 0; cfg_we = 0; cfg_data = '0; in_valid = 0; in_opcode = OP_MOVE1;
    {in_end1_x, in_end1_y, in_end1_z, in_end2_x, in_end2_y, in_end2_z} = '0;
    {in_pt_x, in_pt_y, in_pt_z} = '0;
    repeat (9) @(negedge clk);
    rst_n = 1;

    // directed: every opcode, extremes, degenerate and clamped projections
    for (int k = 0; k < 4; k++) begin
      q.op = OPW'(k);
      for (int i = 0; i < 3; i++) begin
        q.e1[i] = 24'sh800000; q.e2[i] = 24'sh7fffff; q.p[i] = 24'sh7fffff;
      end
      send_query(q);
      for (int i = 0; i < 3; i++) begin
        q.e1[i] = 24'sh7fffff; q.e2[i] = 24'sh800000; q.p[i] = 24'sh800000;
      end
      send_query(q);
      for (int i = 0; i < 3; i++) begin
        q.e1[i] = 0; q.e2[i] = 4096; q.p[i] = (k == 1) ? -4096 : 2048;
      end
      send_query(q);
    end
    q.op = OP_PROJ;
    for (int i = 0; i < 3; i++) begin
      q.e1[i] = 100; q.e2[i] = 100; q.p[i] = 5000;
    end
    send_query(q);                        // zero-length segment, default threshold
    q.e2[0] = 101; send_query(q);         // length at the threshold
    q.p[0] = -9000; send_query(q);        // before the first end
    write_threshold('0);
    q.e2[0] = 100; send_query(q);         // zero threshold, zero length
    write_threshold({THRW{1'b1}});
    send_query(rnd_query());              // every segment counts as a point

    // random phases at several thresholds
    thr_set[0] = 1; thr_set[1] = '0; thr_set[2] = {THRW{1'b1}};
    thr_set[3] = THRW'(64'd1 << 30);
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(ph == 3 ? THRW'({$urandom, $urandom}) : thr_set[ph]);
      for (int n = 0; n < 120; n++) begin
        if (n == 60) drain();
        if (n > 80 && n < 100) begin
          // back-to-back stretch
          q = rnd_query();
          in_opcode <= q.op;
          {in_end1_x, in_end1_y, in_end1_z} <= {q.e1[0], q.e1[1], q.e1[2]};
          {in_end2_x, in_end2_y, in_end2_z} <= {q.e2[0], q.e2[1], q.e2[2]};
          {in_pt_x, in_pt_y, in_pt_z} <= {q.p[0], q.p[1], q.p[2]};
          in_valid <= 1;
          do @(posedge clk); while (in_stall);
          board.note_query(q);
          @(negedge clk);
        end else
          send_query(rnd_query());
      end
    end

    drain();
    stim_done = 1;
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spc_pkg.sv
hw/rtl/segment_point_constraint_unit.sv
hw/rtl/spc_checker.sv
tb/tb.sv
